>>> rtl/core/lrs_pkg.sv
// Link reconnect supervisor: shared types, codes and helpers.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package lrs_pkg;

    // Event codes carried in item.action
    localparam logic [2:0] ACT_TICK         = 3'd0;
    localparam logic [2:0] ACT_CONNECTED    = 3'd1;
    localparam logic [2:0] ACT_GOT_ADDR     = 3'd2;
    localparam logic [2:0] ACT_DISCONNECTED = 3'd3;
    localparam logic [2:0] ACT_CONNECT_REQ  = 3'd4;
    localparam logic [2:0] ACT_AP_ONLY_ON   = 3'd5;
    localparam logic [2:0] ACT_AP_ONLY_OFF  = 3'd6;

    // Link state codes as seen on result.link_state
    localparam logic [2:0] LS_NOADDR   = 3'd0;
    localparam logic [2:0] LS_GOOD     = 3'd1;
    localparam logic [2:0] LS_APONLY   = 3'd2;
    localparam logic [2:0] LS_GENABLE  = 3'd3;
    localparam logic [2:0] LS_GDISABLE = 3'd4;
    localparam logic [2:0] LS_RECON    = 3'd5;
    localparam logic [2:0] LS_COOL     = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_AP_GRACE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_AP     = 3'd3;

    // Register reset values
    localparam logic [7:0] AP_GRACE_RST     = 8'd15;
    localparam logic [7:0] CONN_TIMEOUT_RST = 8'd10;
    localparam logic [7:0] COOLDOWN_RST     = 8'd90;

    // Internal link mode, one-hot
    typedef enum logic [6:0] {
        LM_NOADDR   = 7'b0000001,
        LM_GOOD     = 7'b0000010,
        LM_APONLY   = 7'b0000100,
        LM_GENABLE  = 7'b0001000,
        LM_GDISABLE = 7'b0010000,
        LM_RECON    = 7'b0100000,
        LM_COOL     = 7'b1000000
    } lm_t;

    typedef struct packed {
        logic [2:0] action;
        logic       is_init;
        logic       address_valid;
        logic       ap_active;
        logic       client_active;
    } item_t;

    typedef struct packed {
        logic [2:0] link_state;
        logic       start_client;
        logic       stop_client;
        logic       bring_up_ap;
        logic       force_ap;
        logic       take_down_ap;
        logic       start_name_service;
        logic       schedule_connect;
    } result_t;

    typedef struct packed {
        logic [7:0] ap_grace_ticks;
        logic [7:0] connect_timeout_ticks;
        logic [7:0] cooldown_ticks;
        logic       start_ap_only;
    } cfg_t;

    function automatic logic [2:0] lm_code(input lm_t lm);
        logic [2:0] code;
        case (lm)
            LM_NOADDR:   code = LS_NOADDR;
            LM_GOOD:     code = LS_GOOD;
            LM_APONLY:   code = LS_APONLY;
            LM_GENABLE:  code = LS_GENABLE;
            LM_GDISABLE: code = LS_GDISABLE;
            LM_RECON:    code = LS_RECON;
            LM_COOL:     code = LS_COOL;
            default:     code = LS_NOADDR;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/link_reconnect_supervisor_top.sv
// Link reconnect supervisor top level: input stage, core, result register.
// Depends on lrs_pkg, lrs_cfg_regs and lrs_core.
//
//  channel   signals                                   beat carries
//  -------   ---------------------------------------   ----------------------------
//  item      item_valid, item_ready, item              one event + radio status
//  result    result_valid, result_ready, result        link state + command strobes
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write (always ready)
//
// Flow: an event beat waits in the input register, is evaluated against the
//   supervisor state there and then moves into the result register; one event
//   per cycle sustained while result_ready is high.
// The supervisor state updates at the same edge that loads the result register,
//   so back-to-back events see each other's effects in order.
// Stalls: while result_ready is low the result register holds and the input
//   register can still take one more beat; item_ready drops only when both are full.
// Reset (rst_n low, asynchronous) empties both stages, clears the link state to
//   no address with all counters zero and ticks disabled, and restores the
//   register defaults (grace 15, timeout 10, cooldown 90, AP-only off).
`default_nettype none

module link_reconnect_supervisor_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // event channel
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire lrs_pkg::item_t                 item,
    // result channel
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output lrs_pkg::result_t                    result,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrs_pkg::*;

    cfg_t    cfg;
    result_t core_result;

    logic    item_valid_reg,   item_valid_next;
    item_t   item_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;

    logic    advance;   // result register free for a new beat this cycle
    logic    step;      // held event moves into the result register
    logic    take;      // event beat accepted from the port

    // register writes are always taken
    assign cfg_ready = 1'b1;

    lrs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance    = !result_valid_reg || result_ready;
    assign step       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;
    assign take       = item_valid && item_ready;

    lrs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (step)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (step)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/lrs_cfg_regs.sv
// Configuration register file for the link reconnect supervisor.
// Depends on lrs_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module lrs_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0] wr_data,
    output lrs_pkg::cfg_t                       cfg
);
    import lrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_AP_GRACE:     cfg_next.ap_grace_ticks        = wr_data;
                CFG_CONN_TIMEOUT: cfg_next.connect_timeout_ticks = wr_data;
                CFG_COOLDOWN:     cfg_next.cooldown_ticks        = wr_data;
                CFG_START_AP:     cfg_next.start_ap_only         = wr_data[0];
                default:          cfg_next = cfg_reg; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ap_grace_ticks        <= AP_GRACE_RST;
            cfg_reg.connect_timeout_ticks <= CONN_TIMEOUT_RST;
            cfg_reg.cooldown_ticks        <= COOLDOWN_RST;
            cfg_reg.start_ap_only         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/lrs_core.sv
// Supervisor state registers and per-event update logic.
// Depends on lrs_pkg (item_t, result_t, cfg_t, lm_t, codes).
`default_nettype none

module lrs_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire lrs_pkg::item_t  item,
    input  wire lrs_pkg::cfg_t   cfg,
    output lrs_pkg::result_t result
);
    import lrs_pkg::*;

    lm_t        mode_reg,  mode_next;
    logic [7:0] grace_reg, grace_next;
    logic [7:0] retry_reg, retry_next;
    logic       tick_reg,  tick_next;

    always_comb
    begin
        mode_next  = mode_reg;
        grace_next = grace_reg;
        retry_next = retry_reg;
        tick_next  = tick_reg;
        result     = '0;

        if (item.is_init)
        begin
            if (cfg.start_ap_only || (mode_reg == LM_APONLY))
            begin
                mode_next          = LM_APONLY;
                result.force_ap    = 1'b1;
                result.stop_client = 1'b1;
            end
            else
            begin
                mode_next           = LM_GENABLE;
                grace_next          = cfg.ap_grace_ticks;
                result.start_client = 1'b1;
                tick_next           = 1'b1;
            end
        end
        else
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (tick_reg)
                    begin
                        case (mode_reg)
                            LM_APONLY:
                            begin
                                result.bring_up_ap = 1'b1;
                                result.stop_client = 1'b1;
                                tick_next          = 1'b0;
                            end
                            LM_GDISABLE:
                            begin
                                if (grace_reg != 8'd0)
                                begin
                                    grace_next = grace_reg - 8'd1;
                                    // last grace tick; if client is off we stick at zero
                                    if ((grace_reg == 8'd1) && item.client_active)
                                    begin
                                        result.take_down_ap = 1'b1;
                                        mode_next           = LM_GOOD;
                                        grace_next          = cfg.ap_grace_ticks;
                                    end
                                end
                            end
                            LM_GENABLE:
                            begin
                                if (grace_reg != 8'd0)
                                begin
                                    grace_next = grace_reg - 8'd1;
                                    if ((grace_reg == 8'd1) && !item.ap_active)
                                    begin
                                        result.bring_up_ap = 1'b1;
                                        mode_next          = LM_RECON;
                                        retry_next         = cfg.connect_timeout_ticks;
                                    end
                                end
                            end
                            LM_RECON:
                            begin
                                if (retry_reg != 8'd0)
                                begin
                                    retry_next = retry_reg - 8'd1;
                                    if (retry_reg == 8'd1)
                                    begin
                                        result.stop_client = 1'b1;
                                        mode_next          = LM_COOL;
                                        retry_next         = cfg.cooldown_ticks;
                                    end
                                end
                            end
                            LM_COOL:
                            begin
                                if (retry_reg != 8'd0)
                                begin
                                    retry_next = retry_reg - 8'd1;
                                    if (retry_reg == 8'd1)
                                    begin
                                        result.start_client = 1'b1;
                                        mode_next           = LM_RECON;
                                        retry_next          = cfg.connect_timeout_ticks;
                                    end
                                end
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
                ACT_CONNECTED:
                begin
                    mode_next = LM_NOADDR;
                end
                ACT_GOT_ADDR:
                begin
                    if (item.address_valid)
                    begin
                        if (mode_reg == LM_GENABLE)
                        begin
                            grace_next = 8'd0;
                        end
                        if (item.ap_active)
                        begin
                            mode_next  = LM_GDISABLE;
                            grace_next = cfg.ap_grace_ticks;
                        end
                        else
                        begin
                            mode_next = LM_GOOD;
                        end
                        result.start_name_service = 1'b1;
                    end
                end
                ACT_DISCONNECTED:
                begin
                    if (mode_reg == LM_GOOD)
                    begin
                        mode_next  = LM_GENABLE;
                        grace_next = cfg.ap_grace_ticks;
                    end
                end
                ACT_CONNECT_REQ:
                begin
                    result.schedule_connect = 1'b1;
                    mode_next               = LM_GENABLE;
                    grace_next              = cfg.ap_grace_ticks;
                end
                ACT_AP_ONLY_ON:
                begin
                    mode_next = LM_APONLY;
                    tick_next = 1'b1;
                end
                ACT_AP_ONLY_OFF:
                begin
                    if (mode_reg != LM_GOOD)
                    begin
                        mode_next           = LM_GDISABLE;
                        grace_next          = cfg.ap_grace_ticks;
                        tick_next           = 1'b1;
                        result.start_client = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = mode_reg; // unused code: no effect
                end
            endcase
        end

        result.link_state = lm_code(mode_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= LM_NOADDR;
            grace_reg <= 8'd0;
            retry_reg <= 8'd0;
            tick_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            grace_reg <= grace_next;
            retry_reg <= retry_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lrs_checker.sv
// Port-level checks for the link reconnect supervisor, bound to the top level.
// Depends on lrs_pkg (result_t, link state codes).
`default_nettype none

module lrs_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           result_valid,
    input  wire logic                           result_ready,
    input  wire lrs_pkg::result_t               result
);
    import lrs_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // force_ap only comes from init into AP-only
    a_force_ap_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.force_ap |-> result.link_state == LS_APONLY)
        else $error("force_ap outside AP-only");

    // AP is taken down only on the move to a good link
    a_take_down_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.take_down_ap |-> result.link_state == LS_GOOD)
        else $error("take_down_ap without good link");

    // bring-up happens in AP-only or on entering reconnect
    a_bring_up_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bring_up_ap |->
            (result.link_state == LS_APONLY) || (result.link_state == LS_RECON))
        else $error("bring_up_ap in unexpected state");

    // a connect request always restarts the enable grace period
    a_sched_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.schedule_connect |-> result.link_state == LS_GENABLE)
        else $error("schedule_connect without grace enable");

endmodule

bind link_reconnect_supervisor_top lrs_checker u_lrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
